/* src/waypoint_turn_then_go_controller_defines.svh */
// Assertion macros for the waypoint follower
`ifndef WAYPOINT_TURN_THEN_GO_CONTROLLER_DEFINES_SVH
`define WAYPOINT_TURN_THEN_GO_CONTROLLER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define WTG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WTG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wtg_pkg.sv */
// Shared types, constants and tables of the waypoint follower
package wtg_pkg;

    localparam int MAX_WAYPOINTS = 16;
    localparam int WP_AW         = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = 5;
    localparam int ITER_W        = 5;
    localparam int SQRT_STEPS    = 17;
    localparam int CORDIC_STEPS  = 16;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

    typedef enum logic [1:0] {
        OP_WP_WRITE = 2'd0,
        OP_GOAL     = 2'd1,
        OP_POSE     = 2'd2,
        OP_PREEMPT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_MOTION  = 2'd0,
        KIND_REACHED = 2'd1,
        KIND_SUCCESS = 2'd2,
        KIND_PREEMPT = 2'd3
    } kind_t;

    localparam logic [1:0] REG_LIN_GAIN = 2'd0;
    localparam logic [1:0] REG_ANG_GAIN = 2'd1;
    localparam logic [1:0] REG_DIST_TOL = 2'd2;
    localparam logic [1:0] REG_HEAD_TOL = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LEG, ST_MUL_X, ST_MUL_Y, ST_SQRT,
        ST_LEN, ST_BEAR, ST_SMP, ST_DECIDE, ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        SEL_TURN, SEL_DRIVE, SEL_REACHED, SEL_BOTH, SEL_SUCCESS, SEL_PREEMPT
    } sel_t;

    typedef struct packed {
        logic take;
        logic leg_setup;
        logic smp_setup;
        logic bear_store;
        logic mul_x;
        logic mul_y;
        logic sqrt_step;
        logic leg_store;
        logic cordic_step;
        logic decide;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       active;
        logic       leg_begin;
        logic       done_ge_total;
        logic       sqrt_last;
        logic       cordic_last;
        logic       out_busy;
    } dp_stat_t;

    // arctan(2^-i) in Q.16
    function automatic logic [16:0] atan_q16(input logic [3:0] i);
        logic [16:0] r;
        case (i)
            4'd0:    r = 17'd51472;
            4'd1:    r = 17'd30385;
            4'd2:    r = 17'd16055;
            4'd3:    r = 17'd8150;
            4'd4:    r = 17'd4091;
            4'd5:    r = 17'd2047;
            4'd6:    r = 17'd1024;
            4'd7:    r = 17'd512;
            4'd8:    r = 17'd256;
            4'd9:    r = 17'd128;
            4'd10:   r = 17'd64;
            4'd11:   r = 17'd32;
            4'd12:   r = 17'd16;
            4'd13:   r = 17'd8;
            4'd14:   r = 17'd4;
            default: r = 17'd2;
        endcase
        return r;
    endfunction

endpackage

/* src/wtg_ram.sv */
// Generic single-port-write, registered-read RAM
module wtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* src/wtg_datapath.sv */
// Datapath: run state, waypoint table, square root, CORDIC bearing, speeds
module wtg_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wtg_pkg::dp_cmd_t      cmd,
    output wtg_pkg::dp_stat_t     stat,
    input  logic [1:0]            in_op,
    input  logic signed [15:0]    in_x,
    input  logic signed [15:0]    in_y,
    input  logic signed [15:0]    in_heading,
    input  logic [3:0]            in_slot,
    input  logic [4:0]            in_count,
    input  logic [7:0]            lin_gain,
    input  logic [7:0]            ang_gain,
    input  logic [14:0]           dist_tol,
    input  logic [14:0]           head_tol,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_kind,
    output logic [15:0]           out_lin,
    output logic [15:0]           out_ang,
    output logic [4:0]            out_prog
);
    import wtg_pkg::*;

    // run control
    logic [CNT_W-1:0] total_reg, done_reg;
    logic             active_reg, leg_begin_reg;
    // payload
    logic signed [15:0] pose_x_reg, pose_y_reg, pose_h_reg;
    logic signed [15:0] origin_x_reg, origin_y_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [33:0]        sq_reg, n_reg;
    logic [17:0]        rem_reg;
    logic [16:0]        root_reg, leg_len_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic signed [27:0] cx_reg, cy_reg;
    logic signed [19:0] cz_reg;
    logic               czero_reg;
    logic signed [15:0] leg_bear_reg;
    logic signed [26:0] lin_prod_reg, ang_prod_reg;
    sel_t               sel_reg;
    logic [CNT_W-1:0]   prog_reg;
    // result beat
    logic               m_valid_reg;
    logic [1:0]         m_kind_reg;
    logic [15:0]        m_lin_reg, m_ang_reg;
    logic [4:0]         m_prog_reg;

    op_t         op_in;
    logic        ram_we;
    logic [31:0] ram_rdata;
    logic signed [15:0] wp_x, wp_y;
    logic [16:0] ax, ay;
    logic [19:0] rem_sh, trial;
    logic signed [27:0] ix, iy, xs, ys;
    logic signed [19:0] tab, bear_full;
    logic signed [17:0] derr;
    logic signed [16:0] herr;
    logic [16:0]        habs;
    logic               hfar, dfar, reached;
    logic [CNT_W-1:0]   cnt_sat;

    function automatic logic [15:0] sat16(input logic signed [26:0] p);
        logic signed [26:0] q;
        logic signed [22:0] v;
        q = (p + 27'sd8) >>> 4;
        v = q[22:0];
        if (v > 23'sd32767) begin
            return 16'h7fff;
        end else if (v < -23'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    assign op_in  = op_t'(in_op);
    assign ram_we = cmd.take && (op_in == OP_WP_WRITE);

    wtg_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_wp_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_slot[WP_AW-1:0]),
        .wdata ({in_y, in_x}),
        .raddr (done_reg[WP_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign wp_x = ram_rdata[15:0];
    assign wp_y = ram_rdata[31:16];
    assign cnt_sat = (in_count > CNT_W'(MAX_WAYPOINTS)) ? CNT_W'(MAX_WAYPOINTS) : in_count;

    // magnitudes for squaring
    assign ax = dx_reg[16] ? 17'(-dx_reg) : 17'(dx_reg);
    assign ay = dy_reg[16] ? 17'(-dy_reg) : 17'(dy_reg);

    // one root digit a step
    assign rem_sh = {rem_reg, n_reg[33:32]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // CORDIC pre-rotation inputs and step terms
    assign ix  = {{3{dx_reg[16]}}, dx_reg, 8'b0};
    assign iy  = {{3{dy_reg[16]}}, dy_reg, 8'b0};
    assign xs  = cx_reg >>> iter_reg[3:0];
    assign ys  = cy_reg >>> iter_reg[3:0];
    assign tab = $signed({3'b0, atan_q16(iter_reg[3:0])});
    assign bear_full = (cz_reg + 20'sd8) >>> 4;

    // error terms; the sample distance is the finished root
    assign derr    = $signed({1'b0, leg_len_reg}) - $signed({1'b0, root_reg});
    assign herr    = 17'(leg_bear_reg) - 17'(pose_h_reg);
    assign habs    = herr[16] ? 17'(-herr) : 17'(herr);
    assign hfar    = habs > {2'b0, head_tol};
    assign dfar    = derr > $signed({3'b0, dist_tol});
    assign reached = (derr < $signed({3'b0, dist_tol})) && (habs < {2'b0, head_tol});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            done_reg      <= '0;
            active_reg    <= 1'b0;
            leg_begin_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.take) begin
                case (op_in)
                    OP_GOAL: begin
                        total_reg     <= cnt_sat;
                        done_reg      <= '0;
                        leg_begin_reg <= 1'b1;
                        active_reg    <= 1'b1;
                    end
                    OP_POSE: begin
                        if (active_reg && done_reg >= total_reg) begin
                            active_reg <= 1'b0;
                        end
                    end
                    OP_PREEMPT: begin
                        active_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (cmd.leg_setup) begin
                leg_begin_reg <= 1'b0;
            end
            if (cmd.decide && !hfar && !dfar && reached) begin
                leg_begin_reg <= 1'b1;
                done_reg      <= done_reg + 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pose_x_reg <= in_x;
            pose_y_reg <= in_y;
            pose_h_reg <= in_heading;
            prog_reg   <= done_reg;
            sel_reg    <= (op_in == OP_PREEMPT) ? SEL_PREEMPT : SEL_SUCCESS;
        end
        if (cmd.leg_setup) begin
            origin_x_reg <= pose_x_reg;
            origin_y_reg <= pose_y_reg;
            dx_reg <= 17'(wp_x) - 17'(pose_x_reg);
            dy_reg <= 17'(wp_y) - 17'(pose_y_reg);
        end
        if (cmd.smp_setup) begin
            dx_reg <= 17'(origin_x_reg) - 17'(pose_x_reg);
            dy_reg <= 17'(origin_y_reg) - 17'(pose_y_reg);
        end
        if (cmd.bear_store) begin
            leg_bear_reg <= czero_reg ? 16'sd0 : bear_full[15:0];
        end
        if (cmd.mul_x) begin
            sq_reg    <= ax * ax;
            czero_reg <= (dx_reg == 17'sd0) && (dy_reg == 17'sd0);
            if (ix < 0) begin
                if (iy >= 0) begin
                    cx_reg <= iy;
                    cy_reg <= -ix;
                    cz_reg <= HALF_PI_Q16;
                end else begin
                    cx_reg <= -iy;
                    cy_reg <= ix;
                    cz_reg <= -HALF_PI_Q16;
                end
            end else begin
                cx_reg <= ix;
                cy_reg <= iy;
                cz_reg <= '0;
            end
        end
        if (cmd.mul_y) begin
            n_reg    <= sq_reg + 34'(ay * ay);
            rem_reg  <= '0;
            root_reg <= '0;
            iter_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            if (rem_sh >= trial) begin
                rem_reg  <= 18'(rem_sh - trial);
                root_reg <= {root_reg[15:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[17:0];
                root_reg <= {root_reg[15:0], 1'b0};
            end
            n_reg    <= {n_reg[31:0], 2'b00};
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.leg_store) begin
            leg_len_reg <= root_reg;
            iter_reg    <= '0;
        end
        if (cmd.cordic_step) begin
            if (cy_reg >= 0) begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + tab;
            end else begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - tab;
            end
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.decide) begin
            lin_prod_reg <= $signed({1'b0, lin_gain}) * derr;
            ang_prod_reg <= $signed({1'b0, ang_gain}) * herr;
            prog_reg     <= done_reg;
            if (hfar) begin
                sel_reg <= SEL_TURN;
            end else if (dfar) begin
                sel_reg <= SEL_DRIVE;
            end else if (reached) begin
                sel_reg <= SEL_REACHED;
            end else begin
                sel_reg <= SEL_BOTH;
            end
        end
        if (cmd.emit) begin
            m_lin_reg  <= '0;
            m_ang_reg  <= '0;
            m_prog_reg <= '0;
            case (sel_reg)
                SEL_TURN: begin
                    m_kind_reg <= KIND_MOTION;
                    m_ang_reg  <= sat16(ang_prod_reg);
                end
                SEL_DRIVE: begin
                    m_kind_reg <= KIND_MOTION;
                    m_lin_reg  <= sat16(lin_prod_reg);
                end
                SEL_BOTH: begin
                    m_kind_reg <= KIND_MOTION;
                    m_lin_reg  <= sat16(lin_prod_reg);
                    m_ang_reg  <= sat16(ang_prod_reg);
                end
                SEL_REACHED: begin
                    m_kind_reg <= KIND_REACHED;
                    m_prog_reg <= prog_reg;
                end
                SEL_SUCCESS: begin
                    m_kind_reg <= KIND_SUCCESS;
                    m_prog_reg <= prog_reg;
                end
                default: begin
                    m_kind_reg <= KIND_PREEMPT;
                    m_prog_reg <= prog_reg;
                end
            endcase
        end
    end

    assign stat.op            = in_op;
    assign stat.active        = active_reg;
    assign stat.leg_begin     = leg_begin_reg;
    assign stat.done_ge_total = done_reg >= total_reg;
    assign stat.sqrt_last     = iter_reg == ITER_W'(SQRT_STEPS - 1);
    assign stat.cordic_last   = iter_reg == ITER_W'(CORDIC_STEPS - 1);
    assign stat.out_busy      = m_valid_reg && !out_ready;

    assign out_valid = m_valid_reg;
    assign out_kind  = m_kind_reg;
    assign out_lin   = m_lin_reg;
    assign out_ang   = m_ang_reg;
    assign out_prog  = m_prog_reg;
endmodule

/* src/wtg_ctrl.sv */
// Controller state machine sequencing one item through the datapath
`include "waypoint_turn_then_go_controller_defines.svh"
module wtg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  wtg_pkg::dp_stat_t stat,
    output wtg_pkg::dp_cmd_t  cmd
);
    import wtg_pkg::*;

    state_t state_reg, state_next;
    logic   leg_phase_reg, leg_phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            leg_phase_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            leg_phase_reg <= leg_phase_next;
        end
    end

    // next state
    always_comb begin
        state_next     = state_reg;
        leg_phase_next = leg_phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && stat.active) begin
                    if (stat.op == OP_PREEMPT) begin
                        state_next = ST_EMIT;
                    end else if (stat.op == OP_POSE) begin
                        if (stat.done_ge_total) begin
                            state_next = ST_EMIT;
                        end else if (stat.leg_begin) begin
                            state_next     = ST_LEG;
                            leg_phase_next = 1'b1;
                        end else begin
                            state_next = ST_SMP;
                        end
                    end
                end
            end
            ST_LEG:    state_next = ST_MUL_X;
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_SQRT;
            ST_SQRT: begin
                if (stat.sqrt_last) begin
                    state_next = leg_phase_reg ? ST_LEN : ST_DECIDE;
                end
            end
            ST_LEN:    state_next = ST_BEAR;
            ST_BEAR: begin
                if (stat.cordic_last) begin
                    state_next = ST_SMP;
                end
            end
            ST_SMP: begin
                state_next     = ST_MUL_X;
                leg_phase_next = 1'b0;
            end
            ST_DECIDE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_LEG:    cmd.leg_setup   = 1'b1;
            ST_MUL_X:  cmd.mul_x       = 1'b1;
            ST_MUL_Y:  cmd.mul_y       = 1'b1;
            ST_SQRT:   cmd.sqrt_step   = 1'b1;
            ST_LEN:    cmd.leg_store   = 1'b1;
            ST_BEAR:   cmd.cordic_step = 1'b1;
            ST_SMP: begin
                cmd.smp_setup  = 1'b1;
                cmd.bear_store = leg_phase_reg;
            end
            ST_DECIDE: cmd.decide = 1'b1;
            ST_EMIT:   cmd.emit   = !stat.out_busy;
            default: ;
        endcase
    end

    `WTG_ASSERT_NXT(a_emit_waits, state_reg == ST_EMIT && stat.out_busy, state_reg == ST_EMIT, "result dropped while output busy")
    `WTG_ASSERT_NXT(a_leg_entry, state_reg == ST_IDLE && s_tvalid && stat.active && stat.op == OP_POSE && !stat.done_ge_total && stat.leg_begin, state_reg == ST_LEG && leg_phase_reg, "new leg not started")
    `WTG_ASSERT_NXT(a_sqrt_exit, state_reg == ST_SQRT && stat.sqrt_last, state_reg == ST_LEN || state_reg == ST_DECIDE, "root did not finish")
    `WTG_ASSERT_IMP(a_bear_leg_only, cmd.bear_store, leg_phase_reg && state_reg == ST_SMP, "bearing written outside leg set-up")
endmodule

/* src/waypoint_turn_then_go_controller.sv */
// Top level: stream ports, APB register file, controller and datapath
// Waypoint write, goal start and ignored beats finish in the accept state; preempt and success
// go straight to the result state. A pose sample runs the root and CORDIC steps: two 17-step
// root passes plus a 16-step CORDIC on the first sample of a leg, one root pass otherwise.
// Throughput: one beat at a time; the next beat is taken once the result is in the
// output register. Reset (aresetn, synchronous, low): run idle, counts zero, gains 4.0.
module waypoint_turn_then_go_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // coord_x[15:0] coord_y[31:16] heading[47:32] slot[51:48]
                                  // count[56:52], zero pad above
    input  logic [1:0]  s_tuser,  // op[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // linear_speed[15:0] angular_speed[31:16] progress[36:32]
    output logic [1:0]  m_tuser,  // kind[1:0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wtg_pkg::*;

    logic [7:0]  lin_gain_reg, ang_gain_reg;
    logic [14:0] dist_tol_reg, head_tol_reg;
    logic        cfg_wr;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [15:0] lin_spd, ang_spd;
    logic [4:0]  prog;

    // APB: zero-wait, written in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_gain_reg <= 8'd64;
            ang_gain_reg <= 8'd64;
            dist_tol_reg <= 15'd3;
            head_tol_reg <= 15'd41;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LIN_GAIN: lin_gain_reg <= pwdata[7:0];
                REG_ANG_GAIN: ang_gain_reg <= pwdata[7:0];
                REG_DIST_TOL: dist_tol_reg <= pwdata[14:0];
                REG_HEAD_TOL: head_tol_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LIN_GAIN: prdata = {24'b0, lin_gain_reg};
            REG_ANG_GAIN: prdata = {24'b0, ang_gain_reg};
            REG_DIST_TOL: prdata = {17'b0, dist_tol_reg};
            REG_HEAD_TOL: prdata = {17'b0, head_tol_reg};
            default:      prdata = '0;
        endcase
    end

    // sequencer: one state per datapath step, iterating in the root and CORDIC states
    wtg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // run state, waypoint RAM, arithmetic units and the output register
    wtg_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_x       (s_tdata[15:0]),
        .in_y       (s_tdata[31:16]),
        .in_heading (s_tdata[47:32]),
        .in_slot    (s_tdata[51:48]),
        .in_count   (s_tdata[56:52]),
        .lin_gain   (lin_gain_reg),
        .ang_gain   (ang_gain_reg),
        .dist_tol   (dist_tol_reg),
        .head_tol   (head_tol_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_lin    (lin_spd),
        .out_ang    (ang_spd),
        .out_prog   (prog)
    );

    assign m_tdata = {3'b0, prog, ang_spd, lin_spd};
endmodule
